/* hw/rtl/chained_hash_table_engine_defines.svh */
// Assertion helpers for the chained hash table engine.
`ifndef CHAINED_HASH_TABLE_ENGINE_DEFINES_SVH
`define CHAINED_HASH_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define CHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define CHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/cht_pkg.sv */
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and codes of the chained hash table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cht_pkg;

  localparam int BUCKETS_DEF = 1024;
  localparam int NODES_DEF   = 1024;
  localparam int CFG_W       = 11;
  localparam int CMD_DEPTH   = 2;
  localparam int RES_DEPTH   = 2;

  localparam logic [31:0] HASH_MUL = 32'h27d4eb2d;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_FIND   = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_POOL_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
  } out_item_t;

endpackage

`default_nettype wire

/* hw/rtl/cht_fifo.sv */
// ----------------------------------------------------------------------------
// cht_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cht_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cht_front.sv */
// ----------------------------------------------------------------------------
// cht_front
// Accepts items, hashes the key and reduces it to a bucket index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cht_front #(
  parameter int BUCKETS = 1024,
  parameter int DW      = 11,
  parameter int CMDW    = 77
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire cht_pkg::in_item_t item,
  output logic                   full,
  input  wire logic              clearing,
  input  wire logic [DW-1:0]     m_div,
  output logic                   cmd_push,
  output logic [CMDW-1:0]        cmd_data,
  input  wire logic              cmd_full
);

  import cht_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_LOAD = 3'd2;
  localparam logic [2:0] F_DIV  = 3'd3;
  localparam logic [2:0] F_OUT  = 3'd4;

  logic [2:0]    state;
  in_item_t      op;
  logic [31:0]   mixed;
  logic [31:0]   prod;
  logic [31:0]   dvd;
  logic [DW-1:0] rem;
  logic [DW-1:0] rem_next;
  logic [2:0]    cnt;

  function automatic logic [31:0] premix(input logic [31:0] k);
    logic [31:0] a;
    logic [31:0] b;
    a = (k ^ 32'd61) ^ (k >> 16);
    b = a + (a << 3);
    return b ^ (b >> 4);
  endfunction

  // four restoring divide steps per cycle, remainder only
  always_comb begin
    logic [DW:0]   s;
    logic [DW-1:0] t;
    t = rem;
    for (int i = 0; i < 4; i++) begin
      s = {t, dvd[31-i]};
      if (s >= {1'b0, m_div}) begin
        s = s - {1'b0, m_div};
      end
      t = s[DW-1:0];
    end
    rem_next = t;
  end

  assign full     = (state != F_IDLE) || clearing;
  assign cmd_push = (state == F_OUT) && !cmd_full;
  assign cmd_data = {BW'(rem), op};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push && !full) begin
            op    <= item;
            mixed <= premix(item.key);
            state <= F_MUL;
          end
        end
        F_MUL: begin
          prod  <= 32'(mixed * HASH_MUL);
          state <= F_LOAD;
        end
        F_LOAD: begin
          dvd   <= prod ^ (prod >> 15);
          rem   <= '0;
          cnt   <= '0;
          state <= F_DIV;
        end
        F_DIV: begin
          rem <= rem_next;
          dvd <= dvd << 4;
          cnt <= cnt + 1'b1;
          if (cnt == 3'd7) begin
            state <= F_OUT;
          end
        end
        F_OUT: begin
          if (!cmd_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cht_back.sv */
// ----------------------------------------------------------------------------
// cht_back
// Carries out insert, find and remove on the bucket and node memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cht_back #(
  parameter int BUCKETS = 1024,
  parameter int NODES   = 1024,
  parameter int CMDW    = 77
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_empty,
  input  wire logic [CMDW-1:0] cmd_data,
  output logic                 cmd_pop,
  output logic                 res_push,
  output cht_pkg::out_item_t   res_data,
  input  wire logic            res_full,
  output logic                 clearing
);

  import cht_pkg::*;

  localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW   = $clog2(NODES);
  localparam int MAXN = (BUCKETS > NODES) ? BUCKETS : NODES;
  localparam int CW   = $clog2(MAXN + 1);
  localparam int IW   = $bits(in_item_t);

  localparam logic [2:0] B_CLEAR = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_HEAD  = 3'd2;
  localparam logic [2:0] B_NODE  = 3'd3;
  localparam logic [2:0] B_FREE  = 3'd4;

  typedef struct packed {
    logic          v;
    logic [NW-1:0] idx;
  } ent_t;

  ent_t        heads_mem [BUCKETS];
  ent_t        link_mem  [NODES];
  logic [31:0] key_mem   [NODES];
  logic [31:0] val_mem   [NODES];

  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_inc;
  in_item_t      op;
  logic [BW-1:0] bkt;
  logic [NW-1:0] cur;
  logic [NW-1:0] prev;
  logic          has_prev;
  logic [NW-1:0] free_head;
  logic          free_ok;

  in_item_t      c_item;
  logic [BW-1:0] c_bkt;

  logic [BW-1:0] head_ra;
  ent_t          head_q;
  logic          head_we;
  logic [BW-1:0] head_wa;
  ent_t          head_wd;
  logic [NW-1:0] node_ra;
  ent_t          link_q;
  logic [31:0]   key_q;
  logic [31:0]   val_q;
  logic          link_we;
  logic [NW-1:0] link_wa;
  ent_t          link_wd;
  logic          kv_we;

  assign c_item   = in_item_t'(cmd_data[IW-1:0]);
  assign c_bkt    = cmd_data[CMDW-1 -: BW];
  assign cnt_inc  = cnt + 1'b1;
  assign clearing = (state == B_CLEAR);

  always_comb begin
    head_ra  = c_bkt;
    node_ra  = free_head;
    head_we  = 1'b0;
    head_wa  = bkt;
    head_wd  = '0;
    link_we  = 1'b0;
    link_wa  = free_head;
    link_wd  = head_q;
    kv_we    = 1'b0;
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    res_data = '{status: ST_OK, found_value: 32'd0};
    unique case (state)
      B_CLEAR: begin
        head_we = (cnt < CW'(BUCKETS));
        head_wa = cnt[BW-1:0];
        head_wd = '0;
        link_we = (cnt < CW'(NODES));
        link_wa = cnt[NW-1:0];
        link_wd = '{v: (cnt_inc < CW'(NODES)), idx: cnt_inc[NW-1:0]};
      end
      B_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          if (c_item.func != FUNC_INSERT && c_item.func != FUNC_FIND &&
              c_item.func != FUNC_REMOVE) begin
            res_push = 1'b1;
          end
        end
      end
      B_HEAD: begin
        if (op.func == FUNC_INSERT) begin
          res_push = 1'b1;
          if (!free_ok) begin
            res_data.status = ST_POOL_FULL;
          end else begin
            kv_we   = 1'b1;
            link_we = 1'b1;
            link_wa = free_head;
            link_wd = head_q;
            head_we = 1'b1;
            head_wd = '{v: 1'b1, idx: free_head};
          end
        end else if (!head_q.v) begin
          res_push        = 1'b1;
          res_data.status = ST_NOT_FOUND;
        end else begin
          node_ra = head_q.idx;
        end
      end
      B_NODE: begin
        if (key_q == op.key) begin
          if (op.func == FUNC_FIND) begin
            res_push             = 1'b1;
            res_data.found_value = val_q;
          end else if (has_prev) begin
            link_we = 1'b1;
            link_wa = prev;
            link_wd = link_q;
          end else begin
            head_we = 1'b1;
            head_wd = link_q;
          end
        end else if (link_q.v) begin
          node_ra = link_q.idx;
        end else begin
          res_push        = 1'b1;
          res_data.status = ST_NOT_FOUND;
        end
      end
      B_FREE: begin
        res_push = 1'b1;
        link_we  = 1'b1;
        link_wa  = cur;
        link_wd  = '{v: free_ok, idx: free_head};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    head_q <= heads_mem[head_ra];
    if (head_we) begin
      heads_mem[head_wa] <= head_wd;
    end
  end

  always_ff @(posedge clk) begin
    link_q <= link_mem[node_ra];
    key_q  <= key_mem[node_ra];
    val_q  <= val_mem[node_ra];
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (kv_we) begin
      key_mem[free_head] <= op.key;
      val_mem[free_head] <= op.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      cnt       <= '0;
      free_head <= '0;
      free_ok   <= 1'b1;
      has_prev  <= 1'b0;
    end else begin
      unique case (state)
        B_CLEAR: begin
          cnt <= cnt_inc;
          if (cnt == CW'(MAXN - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (cmd_pop && !res_push) begin
            op    <= c_item;
            bkt   <= c_bkt;
            state <= B_HEAD;
          end
        end
        B_HEAD: begin
          if (op.func == FUNC_INSERT) begin
            if (free_ok) begin
              free_head <= link_q.idx;
              free_ok   <= link_q.v;
            end
            state <= B_IDLE;
          end else if (!head_q.v) begin
            state <= B_IDLE;
          end else begin
            cur      <= head_q.idx;
            has_prev <= 1'b0;
            state    <= B_NODE;
          end
        end
        B_NODE: begin
          if (key_q == op.key) begin
            state <= (op.func == FUNC_FIND) ? B_IDLE : B_FREE;
          end else if (link_q.v) begin
            prev     <= cur;
            cur      <= link_q.idx;
            has_prev <= 1'b1;
          end else begin
            state <= B_IDLE;
          end
        end
        B_FREE: begin
          free_head <= cur;
          free_ok   <= 1'b1;
          state     <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/chained_hash_table_engine.sv */
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Key-to-value map as a chained hash table with a free-listed node pool.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   item      push / full          item   (func, key, value)
//   result    empty / pop          result (status, found_value)
//   config    cfg_we               cfg_data (bucket_count)
//
// Front: one item at a time through accept and mix, multiply, load, 8 divide
// steps at 4 bits each and a hand-off that waits on a full command queue.
// Back: pop, head read, one step per chain node visited and a free step on a
// remove (an undefined func is answered at pop); one memory read port per
// store sets the walk pace.
// After reset a clearing pass over max(BUCKETS, NODES) entries empties the
// buckets and threads the free list; full stays high until it is done.
// The command and result queues let front and back stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chained_hash_table_engine #(
  parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
  parameter int NODES   = cht_pkg::NODES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire cht_pkg::in_item_t        item,
  output logic                          empty,
  input  wire logic                     pop,
  output cht_pkg::out_item_t            result,
  input  wire logic                     cfg_we,
  input  wire logic [cht_pkg::CFG_W-1:0] cfg_data
);

  import cht_pkg::*;

  `include "chained_hash_table_engine_defines.svh"

  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int BCW   = $clog2(BUCKETS + 1);
  localparam int DW    = (BCW > CFG_W) ? BCW : CFG_W;
  localparam int CMDW  = $bits(in_item_t) + BW;
  localparam int RESW  = $bits(out_item_t);

  // bucket count register; use_max stands for the reset value BUCKETS,
  // which may not fit in the register
  logic [CFG_W-1:0] bucket_count;
  logic             use_max;
  logic [DW-1:0]    m_div;

  logic            clearing;
  logic            cmd_push;
  logic [CMDW-1:0] cmd_wdata;
  logic            cmd_full;
  logic            cmd_pop;
  logic [CMDW-1:0] cmd_rdata;
  logic            cmd_empty;
  logic            res_push;
  out_item_t       res_data;
  logic            res_full;
  logic [RESW-1:0] res_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= '0;
      use_max      <= 1'b1;
    end else if (cfg_we) begin
      bucket_count <= cfg_data;
      use_max      <= 1'b0;
    end
  end

  // effective modulus: zero counts as one, above BUCKETS clamps to BUCKETS
  always_comb begin
    if (use_max) begin
      m_div = DW'(BUCKETS);
    end else if (bucket_count == '0) begin
      m_div = DW'(1);
    end else if (DW'(bucket_count) > DW'(BUCKETS)) begin
      m_div = DW'(BUCKETS);
    end else begin
      m_div = DW'(bucket_count);
    end
  end

  cht_front #(
    .BUCKETS (BUCKETS),
    .DW      (DW),
    .CMDW    (CMDW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .clearing (clearing),
    .m_div    (m_div),
    .cmd_push (cmd_push),
    .cmd_data (cmd_wdata),
    .cmd_full (cmd_full)
  );

  cht_fifo #(
    .W     (CMDW),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  cht_back #(
    .BUCKETS (BUCKETS),
    .NODES   (NODES),
    .CMDW    (CMDW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full),
    .clearing  (clearing)
  );

  cht_fifo #(
    .W     (RESW),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign result = out_item_t'(res_rdata);

  // the front works on one item at a time
  `CHT_ASSERT_NEXT(a_front_one_at_a_time, push && !full, full, "front took a second item")
  // nothing reaches either queue before the clearing pass ends
  `CHT_ASSERT_NOW(a_no_cmd_in_clear, clearing, cmd_empty, "command queued during clearing")
  `CHT_ASSERT_NOW(a_no_res_in_clear, clearing, empty, "result queued during clearing")
  // the back only starts an item when the result queue has room
  `CHT_ASSERT_NOW(a_res_room, res_push, !res_full, "result pushed into full queue")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chained hash table engine: a directed table then
// random insert/find/remove traffic over several bucket counts, with each result
// checked against a typed expectation or an in-bench model of the chains and pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import cht_pkg::*;

  localparam int NB         = 1024;
  localparam int NN         = 1024;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] FUNC_NONE = 2'd3;  // undefined op, answered with status OK by the block

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  in_item_t  item = '0;
  out_item_t result;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  chained_hash_table_engine i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // model of the table
  logic [CFG_W-1:0] bkt_count;
  int unsigned      head_node [NB];
  bit               head_vld  [NB];
  logic [31:0]      node_key  [NN];
  logic [31:0]      node_val  [NN];
  int unsigned      node_next [NN];
  bit               next_vld  [NN];
  int unsigned      free_node;
  bit               free_vld;

  out_item_t   pending_q[$];
  int          fails = 0;
  logic [31:0] key_set[64];

  function automatic logic [31:0] mix_hash(logic [31:0] k);
    k = (k ^ 32'd61) ^ (k >> 16);
    k = k + (k << 3);
    k = k ^ (k >> 4);
    k = k * HASH_MUL;
    return k ^ (k >> 15);
  endfunction

  function automatic int unsigned bucket_of(logic [31:0] k);
    int unsigned m;
    m = 32'(bkt_count);
    if (m == 0) m = 1;
    if (m > NB) m = NB;
    return mix_hash(k) % m;
  endfunction

  task automatic table_reset();
    bkt_count = CFG_W'(NB);
    for (int i = 0; i < NB; i++) head_vld[i] = 1'b0;
    for (int i = 0; i < NN; i++) begin
      node_next[i] = i + 1;
      next_vld[i]  = (i + 1) < NN;
    end
    free_node = 0;
    free_vld  = 1'b1;
  endtask

  // Apply one op to the model and return the result it gives.
  task automatic table_op(input in_item_t it, output out_item_t r);
    int unsigned b, cur, prv, steps, n;
    bit ok, has_prv;
    b = bucket_of(it.key);
    r = '0;
    if (it.func == FUNC_INSERT) begin
      if (!free_vld || free_node >= NN) begin
        r.status = ST_POOL_FULL;
      end else begin
        n = free_node;
        free_vld     = next_vld[n];
        free_node    = node_next[n];
        node_key[n]  = it.key;
        node_val[n]  = it.value;
        node_next[n] = head_node[b];
        next_vld[n]  = head_vld[b];
        head_node[b] = n;
        head_vld[b]  = 1'b1;
      end
    end else if (it.func == FUNC_FIND || it.func == FUNC_REMOVE) begin
      cur = head_node[b];
      ok = head_vld[b];
      prv = 0;
      has_prv = 1'b0;
      steps = 0;
      r.status = ST_NOT_FOUND;
      while (ok && cur < NN && steps < NN) begin
        if (node_key[cur] == it.key) begin
          r.status = ST_OK;
          if (it.func == FUNC_FIND) begin
            r.found_value = node_val[cur];
          end else begin
            if (has_prv) begin
              node_next[prv] = node_next[cur];
              next_vld[prv]  = next_vld[cur];
            end else begin
              head_node[b] = node_next[cur];
              head_vld[b]  = next_vld[cur];
            end
            node_next[cur] = free_node;
            next_vld[cur]  = free_vld;
            free_node = cur;
            free_vld  = 1'b1;
          end
          break;
        end
        prv = cur;
        has_prv = 1'b1;
        ok = next_vld[cur];
        cur = node_next[cur];
        steps++;
      end
    end
  endtask

  // Mostly no gap, some short, a few long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t got;
    int g;
    item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    table_op(it, got);
    pending_q.push_back(typed ? want : got);
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Register write with the block idle: sender stopped and all results back.
  task automatic set_buckets(input logic [CFG_W-1:0] v);
    push <= 1'b0;
    @(posedge clk);
    wait (pending_q.size() == 0);
    repeat (40) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    bkt_count = v;
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom;
    return key_set[6'($urandom_range(63))];
  endfunction

  // ins / fnd are percentages; the rest is remove, with a few undefined ops.
  task automatic random_phase(input int count, input int ins, input int fnd);
    in_item_t it;
    int p;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(99);
      if (p < 3)              it.func = FUNC_NONE;
      else if (p < ins)       it.func = FUNC_INSERT;
      else if (p < ins + fnd) it.func = FUNC_FIND;
      else                    it.func = FUNC_REMOVE;
      it.key   = pick_key();
      it.value = $urandom;
      send_item(it, 1'b0, '0);
    end
  endtask

  // Directed table: typed expectations where obvious, model elsewhere.
  typedef struct {
    logic [1:0]  func;
    logic [31:0] key;
    logic [31:0] value;
    bit          typed;
    logic [1:0]  status;
    logic [31:0] found;
  } row_t;

  row_t rows[] = '{
    '{FUNC_FIND,   32'h0,        32'h0,        1, ST_NOT_FOUND, 32'h0},
    '{FUNC_REMOVE, 32'hffffffff, 32'hffffffff, 1, ST_NOT_FOUND, 32'h0},
    '{FUNC_INSERT, 32'h0,        32'hffffffff, 1, ST_OK,        32'h0},
    '{FUNC_FIND,   32'h0,        32'h0,        1, ST_OK,        32'hffffffff},
    '{FUNC_INSERT, 32'hffffffff, 32'h0,        1, ST_OK,        32'h0},
    '{FUNC_FIND,   32'hffffffff, 32'h5a5a5a5a, 1, ST_OK,        32'h0},
    '{FUNC_NONE,   32'h0,        32'h0,        1, ST_OK,        32'h0},
    '{FUNC_INSERT, 32'h0,        32'h12345678, 1, ST_OK,        32'h0},
    '{FUNC_FIND,   32'h0,        32'h0,        1, ST_OK,        32'h12345678},
    '{FUNC_REMOVE, 32'h0,        32'h0,        1, ST_OK,        32'h0},
    '{FUNC_FIND,   32'h0,        32'h0,        1, ST_OK,        32'hffffffff},
    '{FUNC_INSERT, 32'h80000000, 32'h7fffffff, 0, ST_OK,        32'h0},
    '{FUNC_FIND,   32'h80000000, 32'h0,        0, ST_OK,        32'h0},
    '{FUNC_REMOVE, 32'h0,        32'h0,        1, ST_OK,        32'h0},
    '{FUNC_FIND,   32'h0,        32'h0,        1, ST_NOT_FOUND, 32'h0},
    '{FUNC_REMOVE, 32'hffffffff, 32'h0,        1, ST_OK,        32'h0},
    '{FUNC_NONE,   32'hffffffff, 32'hffffffff, 1, ST_OK,        32'h0}
  };

  bit stim_done = 1'b0;

  initial begin
    in_item_t  it;
    out_item_t want;
    table_reset();
    foreach (key_set[i]) key_set[i] = $urandom;
    key_set[0] = 32'h0;
    key_set[1] = 32'hffffffff;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      it   = '{func: rows[i].func, key: rows[i].key, value: rows[i].value};
      want = '{status: rows[i].status, found_value: rows[i].found};
      send_item(it, rows[i].typed, want);
    end

    // single chain, then a zero count (treated as one)
    set_buckets(11'd1);
    random_phase(250, 40, 30);
    set_buckets(11'd0);
    random_phase(150, 40, 30);
    // above range clamps to full size; mostly inserts to run the pool dry
    set_buckets(11'h7ff);
    random_phase(1050, 93, 4);
    set_buckets(11'd1024);
    random_phase(500, 30, 25);

    push <= 1'b0;
    @(posedge clk);
    wait (pending_q.size() == 0);
    stim_done = 1'b1;
  end

  // Result side: check on each accepted result, pop with random gaps.
  int pop_wait = 0;
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_q.size() == 0) begin
          $display("%0t unexpected result status %0d value %h", $time,
                   result.status, result.found_value);
          fails++;
        end else begin
          e = pending_q.pop_front();
          if (e.status !== result.status) begin
            $display("%0t status: expected %0d, got %0d", $time, e.status, result.status);
            fails++;
          end
          if (e.found_value !== result.found_value) begin
            $display("%0t found_value: expected %h, got %h", $time,
                     e.found_value, result.found_value);
            fails++;
          end
        end
        pop_wait = gap_len();
      end
      if (pop_wait > 0) begin
        pop <= 1'b0;
        pop_wait--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no item moving either way.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** chained_hash_table_engine: FAILED **");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    repeat (60) @(posedge clk);
    if (fails == 0 && pending_q.size() == 0) begin
      $display("** chained_hash_table_engine: PASSED **");
    end else begin
      $display("** chained_hash_table_engine: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
